/* src/can_filter_slot_allocator_macros.svh */
// Assertion macros for the CAN filter slot allocator.
// Expects i_clk and i_rst_n in the scope of the module that uses them.
`ifndef CAN_FILTER_SLOT_ALLOCATOR_MACROS_SVH
`define CAN_FILTER_SLOT_ALLOCATOR_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define CFSA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled in reset.
`define CFSA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/cfsa_pkg.sv */
`timescale 1ns / 1ps
// Package for the CAN filter slot allocator: field widths, codes,
// controller states and the command/status structs. No dependencies.
package cfsa_pkg;

    localparam int CHANNELS_DEF          = 2;
    localparam int SLOTS_PER_CHANNEL_DEF = 14;
    localparam int ID_COUNT_DEF          = 2048;

    localparam int ID_W       = 12;
    localparam int CH_W       = 2;
    localparam int REF_W      = 4;
    localparam int SLOT_IDX_W = 5;
    localparam int SLOT_ID_W  = 11;

    typedef enum logic {
        OP_ADD = 1'b0,
        OP_DEL = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_BAD_ARG = 2'd1,
        STAT_FULL    = 2'd2,
        STAT_ABSENT  = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOKUP,
        S_EVAL,
        S_SCAN,
        S_COMMIT,
        S_OUT
    } t_state;

    typedef struct packed {
        logic clear_wr;
        logic take;
        logic lookup;
        logic eval;
        logic scan_step;
        logic commit;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic in_valid;
        logic clear_last;
        logic need_scan;
        logic scan_last;
        logic out_free;
    } t_sts;

endpackage

/* src/cfsa_if.sv */
`timescale 1ns / 1ps
// Request and result channel interfaces (valid/ready).
// Depends on cfsa_pkg.
interface cfsa_in_if;
    logic                          valid;
    logic                          ready;
    cfsa_pkg::t_op                 operation;
    logic [cfsa_pkg::ID_W-1:0]     message_id;
    logic [cfsa_pkg::CH_W-1:0]     channel;

    modport source (output valid, output operation, output message_id, output channel,
                    input ready);
    modport sink   (input valid, input operation, input message_id, input channel,
                    output ready);
endinterface

interface cfsa_out_if;
    logic                            valid;
    logic                            ready;
    cfsa_pkg::t_status               status;
    logic                            slot_changed;
    logic [cfsa_pkg::SLOT_IDX_W-1:0] slot_index;
    logic [cfsa_pkg::REF_W-1:0]      ref_count;

    modport source (output valid, output status, output slot_changed, output slot_index,
                    output ref_count, input ready);
    modport sink   (input valid, input status, input slot_changed, input slot_index,
                    input ref_count, output ready);
endinterface

/* src/can_filter_slot_allocator.sv */
`timescale 1ns / 1ps
// Channel   Dir  Item
// i_in      in   operation, message_id, channel
// o_out     out  status, slot_changed, slot_index, ref_count
//
// One item at a time: once an item is taken, ready stays low through the lookup,
// evaluation, slot scan (when needed), commit and result hand-off states.
// The slot scan runs when a new id looks for an empty slot or a last delete
// looks for its slot; it checks one slot per cycle, up to SLOTS_PER_CHANNEL.
// After reset the count RAM is swept clear, all CHANNELS*ID_COUNT words, with
// ready low. A stalled result holds in the output register; the next result
// waits in the hand-off state, with ready low, until the register is free.
// Depends on cfsa_pkg, cfsa_if, cfsa_ctrl, cfsa_dp.
module can_filter_slot_allocator #(
    parameter int CHANNELS          = cfsa_pkg::CHANNELS_DEF,
    parameter int SLOTS_PER_CHANNEL = cfsa_pkg::SLOTS_PER_CHANNEL_DEF,
    parameter int ID_COUNT          = cfsa_pkg::ID_COUNT_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    cfsa_in_if.sink    i_in,
    cfsa_out_if.source o_out
);

    cfsa_pkg::t_cmd cmd;
    cfsa_pkg::t_sts sts;

    cfsa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    cfsa_dp #(
        .CHANNELS          (CHANNELS),
        .SLOTS_PER_CHANNEL (SLOTS_PER_CHANNEL),
        .ID_COUNT          (ID_COUNT)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .i_in    (i_in),
        .o_out   (o_out)
    );

endmodule

/* src/cfsa_ram.sv */
`timescale 1ns / 1ps
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module cfsa_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 4096,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* src/cfsa_dp.sv */
`timescale 1ns / 1ps
// Datapath: request latch, reference-count RAM, slot table, channel totals,
// slot scan and result register. Depends on cfsa_pkg, cfsa_if, cfsa_ram.
`include "can_filter_slot_allocator_macros.svh"

module cfsa_dp #(
    parameter int CHANNELS          = cfsa_pkg::CHANNELS_DEF,
    parameter int SLOTS_PER_CHANNEL = cfsa_pkg::SLOTS_PER_CHANNEL_DEF,
    parameter int ID_COUNT          = cfsa_pkg::ID_COUNT_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  cfsa_pkg::t_cmd i_cmd,
    output cfsa_pkg::t_sts o_sts,
    cfsa_in_if.sink        i_in,
    cfsa_out_if.source     o_out
);

    localparam int TOTAL  = CHANNELS * SLOTS_PER_CHANNEL;
    localparam int DEPTH  = CHANNELS * ID_COUNT;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SL_W   = (TOTAL > 1) ? $clog2(TOTAL) : 1;
    localparam int K_W    = (SLOTS_PER_CHANNEL > 1) ? $clog2(SLOTS_PER_CHANNEL) : 1;
    localparam int CHI_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int REF_W  = cfsa_pkg::REF_W;
    localparam int ID_W   = cfsa_pkg::ID_W;
    localparam int SID_W  = cfsa_pkg::SLOT_ID_W;

    // Request latch
    cfsa_pkg::t_op     r_op;
    logic [ID_W-1:0]   r_id;
    logic [CHI_W-1:0]  r_chi;
    logic              r_bad;
    logic [ADDR_W-1:0] r_key;
    logic [SL_W-1:0]   r_base;
    logic              n_bad;
    logic [ADDR_W-1:0] n_key;

    // Decision from the lookup
    cfsa_pkg::t_status r_status;
    logic [REF_W-1:0]  r_cnt_new;
    logic              r_mem_wr;
    logic              r_inc;
    logic              r_dec;
    logic              r_scan;

    // Slot scan
    logic [K_W-1:0]    r_k;
    logic [SL_W-1:0]   r_gidx;
    logic              r_found;
    logic [SL_W-1:0]   r_hit;

    // State stores
    logic [TOTAL-1:0]  r_slot_valid;
    logic [SID_W-1:0]  r_slot_id [TOTAL];
    logic [REF_W-1:0]  r_chrefs [CHANNELS];
    logic [ADDR_W-1:0] r_clr;

    // Result register
    logic                            r_out_valid;
    cfsa_pkg::t_status               r_out_status;
    logic                            r_out_changed;
    logic [cfsa_pkg::SLOT_IDX_W-1:0] r_out_idx;
    logic [REF_W-1:0]                r_out_cnt;

    // Combinational
    logic [REF_W-1:0]  rd_cnt;
    logic [REF_W-1:0]  cur_chref;
    cfsa_pkg::t_status e_status;
    logic [REF_W-1:0]  e_cnt;
    logic              e_mem_wr;
    logic              e_inc;
    logic              e_dec;
    logic              e_scan;
    logic              s_valid;
    logic              s_hit;
    logic              c_ok;
    logic              c_changed;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [REF_W-1:0]  ram_wdata;

    assign n_bad = (32'(i_in.message_id) >= ID_COUNT) || (32'(i_in.channel) >= CHANNELS);
    assign n_key = n_bad ? '0
                 : ADDR_W'(32'(i_in.channel) * ID_COUNT + 32'(i_in.message_id));

    assign i_in.ready = i_cmd.take;

    always_ff @(posedge i_clk) begin
        if (i_cmd.take && i_in.valid) begin
            r_op   <= i_in.operation;
            r_id   <= i_in.message_id;
            r_chi  <= i_in.channel[CHI_W-1:0];
            r_bad  <= n_bad;
            r_key  <= n_key;
            r_base <= SL_W'(32'(i_in.channel) * SLOTS_PER_CHANNEL);
        end
    end

    // Reference-count store, cleared by a sweep after reset
    assign ram_we    = i_cmd.clear_wr || (i_cmd.commit && c_ok && r_mem_wr);
    assign ram_waddr = i_cmd.clear_wr ? r_clr : r_key;
    assign ram_wdata = i_cmd.clear_wr ? '0 : r_cnt_new;

    cfsa_ram #(
        .WIDTH (REF_W),
        .DEPTH (DEPTH),
        .AW    (ADDR_W)
    ) u_refcnt_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (i_cmd.lookup),
        .i_raddr (r_key),
        .o_rdata (rd_cnt)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (i_cmd.clear_wr) begin
            r_clr <= r_clr + 1'b1;
        end
    end

    // Lookup evaluation
    assign cur_chref = r_chrefs[r_chi];

    always_comb begin
        e_status = cfsa_pkg::STAT_OK;
        e_cnt    = '0;
        e_mem_wr = 1'b0;
        e_inc    = 1'b0;
        e_dec    = 1'b0;
        e_scan   = 1'b0;
        if (r_bad) begin
            e_status = cfsa_pkg::STAT_BAD_ARG;
        end else if (r_op == cfsa_pkg::OP_ADD) begin
            if (cur_chref >= REF_W'(SLOTS_PER_CHANNEL)) begin
                e_status = cfsa_pkg::STAT_FULL;
                e_cnt    = rd_cnt;
            end else if (rd_cnt == '0) begin
                e_scan   = 1'b1;
                e_cnt    = REF_W'(1);
                e_mem_wr = 1'b1;
                e_inc    = 1'b1;
            end else begin
                e_cnt    = rd_cnt + 1'b1;
                e_mem_wr = 1'b1;
                e_inc    = 1'b1;
            end
        end else begin
            if (rd_cnt == '0) begin
                e_status = cfsa_pkg::STAT_ABSENT;
            end else begin
                e_cnt    = rd_cnt - 1'b1;
                e_mem_wr = 1'b1;
                e_dec    = 1'b1;
                e_scan   = (rd_cnt == REF_W'(1));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.eval) begin
            r_status  <= e_status;
            r_cnt_new <= e_cnt;
            r_mem_wr  <= e_mem_wr;
            r_inc     <= e_inc;
            r_dec     <= e_dec;
            r_scan    <= e_scan;
        end
    end

    // Slot scan: one slot of the channel partition per cycle
    assign s_valid = r_slot_valid[r_gidx];
    assign s_hit   = (r_op == cfsa_pkg::OP_ADD) ? !s_valid
                   : (s_valid && (r_slot_id[r_gidx] == r_id[SID_W-1:0])
                      && (r_id[ID_W-1:SID_W] == '0));

    always_ff @(posedge i_clk) begin
        if (i_cmd.eval) begin
            r_k     <= '0;
            r_gidx  <= r_base;
            r_found <= 1'b0;
        end else if (i_cmd.scan_step) begin
            r_k    <= r_k + 1'b1;
            r_gidx <= r_gidx + 1'b1;
            if (s_hit) begin
                r_found <= 1'b1;
                r_hit   <= r_gidx;
            end
        end
    end

    // An add whose scan found no empty slot is refused as full
    assign c_ok      = !(r_scan && (r_op == cfsa_pkg::OP_ADD) && !r_found);
    assign c_changed = c_ok && r_scan && r_found;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_valid <= '0;
            for (int c = 0; c < CHANNELS; c++) begin
                r_chrefs[c] <= '0;
            end
        end else if (i_cmd.commit && c_ok) begin
            if (r_inc) begin
                r_chrefs[r_chi] <= r_chrefs[r_chi] + 1'b1;
            end
            if (r_dec && (r_chrefs[r_chi] != '0)) begin
                r_chrefs[r_chi] <= r_chrefs[r_chi] - 1'b1;
            end
            if (r_scan && r_found) begin
                r_slot_valid[r_hit] <= (r_op == cfsa_pkg::OP_ADD);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && c_changed && (r_op == cfsa_pkg::OP_ADD)) begin
            r_slot_id[r_hit] <= r_id[SID_W-1:0];
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_status  <= c_ok ? r_status : cfsa_pkg::STAT_FULL;
            r_out_changed <= c_changed;
            r_out_idx     <= c_changed ? cfsa_pkg::SLOT_IDX_W'(r_hit) : '0;
            r_out_cnt     <= c_ok ? r_cnt_new : '0;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.status       = r_out_status;
    assign o_out.slot_changed = r_out_changed;
    assign o_out.slot_index   = r_out_idx;
    assign o_out.ref_count    = r_out_cnt;

    assign o_sts.in_valid   = i_in.valid;
    assign o_sts.clear_last = (r_clr == ADDR_W'(DEPTH - 1));
    assign o_sts.need_scan  = e_scan;
    assign o_sts.scan_last  = s_hit || (r_k == K_W'(SLOTS_PER_CHANNEL - 1));
    assign o_sts.out_free   = !r_out_valid || o_out.ready;

    for (genvar c = 0; c < CHANNELS; c++) begin : g_chk
        `CFSA_ASSERT_NOW(a_refs_bound, 1'b1, r_chrefs[c] <= REF_W'(SLOTS_PER_CHANNEL), "channel total above slot count")
        `CFSA_ASSERT_NOW(a_slots_le_refs, 1'b1, $countones(r_slot_valid[c*SLOTS_PER_CHANNEL +: SLOTS_PER_CHANNEL]) <= int'(r_chrefs[c]), "more filled slots than references")
    end
    `CFSA_ASSERT_NOW(a_scan_bound, i_cmd.scan_step, r_k <= K_W'(SLOTS_PER_CHANNEL - 1), "scan ran past the partition")
    `CFSA_ASSERT_NEXT(a_take_once, i_cmd.take && i_in.valid, !i_in.ready, "ready held after an item was taken")
    `CFSA_ASSERT_NOW(a_changed_ok, r_out_valid && r_out_changed, r_out_status == cfsa_pkg::STAT_OK, "slot change with error status")

endmodule

/* src/cfsa_ctrl.sv */
`timescale 1ns / 1ps
// Controller FSM: clear sweep, lookup, slot scan, commit, result hand-off.
// Depends on cfsa_pkg.
module cfsa_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  cfsa_pkg::t_sts i_sts,
    output cfsa_pkg::t_cmd o_cmd
);

    cfsa_pkg::t_state r_state;
    cfsa_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cfsa_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            cfsa_pkg::S_CLEAR: begin
                if (i_sts.clear_last) begin
                    n_state = cfsa_pkg::S_IDLE;
                end
            end
            cfsa_pkg::S_IDLE: begin
                if (i_sts.in_valid) begin
                    n_state = cfsa_pkg::S_LOOKUP;
                end
            end
            cfsa_pkg::S_LOOKUP: begin
                n_state = cfsa_pkg::S_EVAL;
            end
            cfsa_pkg::S_EVAL: begin
                n_state = i_sts.need_scan ? cfsa_pkg::S_SCAN : cfsa_pkg::S_COMMIT;
            end
            cfsa_pkg::S_SCAN: begin
                if (i_sts.scan_last) begin
                    n_state = cfsa_pkg::S_COMMIT;
                end
            end
            cfsa_pkg::S_COMMIT: begin
                n_state = cfsa_pkg::S_OUT;
            end
            cfsa_pkg::S_OUT: begin
                if (i_sts.out_free) begin
                    n_state = cfsa_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = cfsa_pkg::S_CLEAR;
            end
        endcase
    end

    always_comb begin
        o_cmd = '0;
        case (r_state)
            cfsa_pkg::S_CLEAR:  o_cmd.clear_wr  = 1'b1;
            cfsa_pkg::S_IDLE:   o_cmd.take      = 1'b1;
            cfsa_pkg::S_LOOKUP: o_cmd.lookup    = 1'b1;
            cfsa_pkg::S_EVAL:   o_cmd.eval      = 1'b1;
            cfsa_pkg::S_SCAN:   o_cmd.scan_step = 1'b1;
            cfsa_pkg::S_COMMIT: o_cmd.commit    = 1'b1;
            cfsa_pkg::S_OUT:    o_cmd.load_out  = i_sts.out_free;
            default:            o_cmd           = '0;
        endcase
    end

endmodule

/* test/can_filter_slot_allocator_tb.sv */
`timescale 1ns / 1ps
// Testbench for can_filter_slot_allocator: directed and random add/delete items
// against a built-in filter slot model, with random gaps and result back-pressure.
// Depends on cfsa_pkg, cfsa_if and the allocator RTL.
module can_filter_slot_allocator_tb;
    import cfsa_pkg::*;

    localparam int NCH        = CHANNELS_DEF;
    localparam int NSLOT      = SLOTS_PER_CHANNEL_DEF;
    localparam int NIDS       = ID_COUNT_DEF;
    localparam int CHX_W      = (NCH > 1) ? $clog2(NCH) : 1;
    localparam int IDX_W      = (NIDS > 1) ? $clog2(NIDS) : 1;
    localparam int POOL       = 24;
    localparam int LONG_HOLD  = 300;
    localparam int END_WAIT   = 40;
    // clear sweep after reset covers all NCH*NIDS addresses with ready low
    localparam int IDLE_LIMIT = 20000;

    typedef struct packed {
        t_status                 status;
        logic                    changed;
        logic [SLOT_IDX_W-1:0]   index;
        logic [REF_W-1:0]        count;
    } t_filt_result;

    logic i_clk;
    logic i_rst_n;

    cfsa_in_if  req_ch ();
    cfsa_out_if res_ch ();

    can_filter_slot_allocator dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_ch),
        .o_out   (res_ch)
    );

    // filter state model
    logic [REF_W-1:0]     id_refs    [NCH][NIDS];
    bit                   slot_used  [NCH*NSLOT];
    logic [SLOT_ID_W-1:0] slot_tag   [NCH*NSLOT];
    logic [REF_W-1:0]     chan_total [NCH];

    t_filt_result expected_q [$];
    logic [ID_W-1:0] id_pool [NCH][POOL];

    bit gaps_on;
    bit hold_off_req;
    int fail_count;
    int items_sent;
    int n_checked, n_bad, n_full, n_absent, n_slot_chg;
    int idle_cycles;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic t_filt_result apply_request(t_op op, logic [ID_W-1:0] id,
                                                   logic [CH_W-1:0] ch);
        t_filt_result r;
        int base;
        int k;
        logic [REF_W-1:0] cnt;
        logic [CHX_W-1:0] ci;
        logic [IDX_W-1:0] ii;
        r = '0;
        if (id >= NIDS || ch >= NCH) begin
            r.status = STAT_BAD_ARG;
            return r;
        end
        ci   = ch[CHX_W-1:0];
        ii   = id[IDX_W-1:0];
        cnt  = id_refs[ci][ii];
        base = ch * NSLOT;
        k    = -1;
        if (op == OP_ADD) begin
            if (chan_total[ci] >= NSLOT) begin
                r.status = STAT_FULL;
                r.count  = cnt;
                return r;
            end
            if (cnt == 0) begin
                for (int j = 0; j < NSLOT; j++)
                    if (k < 0 && !slot_used[base + j]) k = j;
                if (k < 0) begin
                    r.status = STAT_FULL;
                    return r;
                end
                slot_used[base + k] = 1'b1;
                slot_tag[base + k]  = id[SLOT_ID_W-1:0];
                id_refs[ci][ii]     = REF_W'(1);
                chan_total[ci]      = chan_total[ci] + 1'b1;
                r.changed = 1'b1;
                r.index   = SLOT_IDX_W'(base + k);
                r.count   = REF_W'(1);
                return r;
            end
            id_refs[ci][ii] = cnt + 1'b1;
            chan_total[ci]  = chan_total[ci] + 1'b1;
            r.count = cnt + 1'b1;
            return r;
        end
        if (cnt == 0) begin
            r.status = STAT_ABSENT;
            return r;
        end
        id_refs[ci][ii] = cnt - 1'b1;
        if (chan_total[ci] > 0) chan_total[ci] = chan_total[ci] - 1'b1;
        r.count = cnt - 1'b1;
        if (cnt == 1) begin
            for (int j = 0; j < NSLOT; j++)
                if (k < 0 && slot_used[base + j] && slot_tag[base + j] == id[SLOT_ID_W-1:0])
                    k = j;
            if (k >= 0) begin
                slot_used[base + k] = 1'b0;
                r.changed = 1'b1;
                r.index   = SLOT_IDX_W'(base + k);
            end
        end
        return r;
    endfunction

    function automatic int pick_gap();
        int roll;
        if (!gaps_on) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 85) return $urandom_range(0, 2);
        if (roll < 97) return $urandom_range(3, 10);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_req(t_op op, logic [ID_W-1:0] id, logic [CH_W-1:0] ch);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.operation  <= op;
        req_ch.message_id <= id;
        req_ch.channel    <= ch;
        do @(posedge i_clk); while (!req_ch.ready);
        expected_q.push_back(apply_request(op, id, ch));
        items_sent++;
    endtask

    task automatic drain_results();
        req_ch.valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_bad_args();
        send_req(OP_ADD, 12'd2048, 2'd0);
        send_req(OP_DEL, 12'd4095, 2'd1);
        send_req(OP_ADD, 12'd0,    2'd2);
        send_req(OP_DEL, 12'd100,  2'd3);
        send_req(OP_ADD, 12'd4095, 2'd3);
        drain_results();
    endtask

    task automatic test_add_delete();
        send_req(OP_DEL, 12'd7,    2'd0);
        send_req(OP_ADD, 12'd0,    2'd0);
        send_req(OP_ADD, 12'd2047, 2'd0);
        send_req(OP_ADD, 12'd0,    2'd0);
        send_req(OP_ADD, 12'd2047, 2'd1);
        send_req(OP_DEL, 12'd0,    2'd0);
        send_req(OP_DEL, 12'd0,    2'd0);
        send_req(OP_ADD, 12'd1365, 2'd0);
        send_req(OP_DEL, 12'd2047, 2'd0);
        send_req(OP_DEL, 12'd1365, 2'd0);
        send_req(OP_DEL, 12'd2047, 2'd1);
        send_req(OP_DEL, 12'd2047, 2'd1);
        drain_results();
    endtask

    // distinct ids fill channel 1, then one id takes all refs of channel 0
    task automatic test_channel_full();
        logic [ID_W-1:0] start;
        logic [ID_W-1:0] id;
        start = ID_W'($urandom_range(0, NIDS - 1));
        for (int k = 0; k <= NSLOT; k++) begin
            id = ID_W'((start + k * 97) % NIDS);
            send_req(OP_ADD, id, 2'd1);
        end
        send_req(OP_ADD, start, 2'd1);
        for (int k = NSLOT - 1; k >= 0; k--) begin
            id = ID_W'((start + k * 97) % NIDS);
            send_req(OP_DEL, id, 2'd1);
        end
        id = ID_W'($urandom_range(0, NIDS - 1));
        for (int k = 0; k <= NSLOT; k++) send_req(OP_ADD, id, 2'd0);
        for (int k = 0; k <= NSLOT; k++) send_req(OP_DEL, id, 2'd0);
        drain_results();
    endtask

    task automatic test_backpressure();
        gaps_on      = 1'b0;
        hold_off_req = 1'b1;
        for (int k = 0; k < 12; k++)
            send_req(t_op'(k % 3 == 2), id_pool[k % NCH][k % 4], CH_W'(k % NCH));
        drain_results();
        gaps_on = 1'b1;
    endtask

    task automatic test_random_traffic(int n_items);
        int done;
        int phase_len;
        int add_pct;
        int noise_pct;
        t_op op;
        logic [ID_W-1:0] id;
        logic [CH_W-1:0] ch;
        done = 0;
        while (done < n_items) begin
            phase_len = $urandom_range(20, 80);
            case ($urandom_range(0, 3))
                0: add_pct = 85;
                1: add_pct = 20;
                default: add_pct = 55;
            endcase
            noise_pct = $urandom_range(0, 1) ? 5 : 15;
            gaps_on   = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 9) == 0) hold_off_req = 1'b1;
            for (int i = 0; i < phase_len; i++) begin
                if ($urandom_range(0, 99) < noise_pct) begin
                    op = t_op'($urandom_range(0, 1));
                    id = ID_W'($urandom_range(0, 4095));
                    ch = CH_W'($urandom_range(0, 3));
                end else begin
                    ch = CH_W'($urandom_range(0, NCH - 1));
                    if ($urandom_range(0, 9) == 0) id = ID_W'($urandom_range(0, NIDS - 1));
                    else id = id_pool[ch[CHX_W-1:0]][$urandom_range(0, POOL - 1)];
                    op = ($urandom_range(0, 99) < add_pct) ? OP_ADD : OP_DEL;
                end
                send_req(op, id, ch);
            end
            done += phase_len;
            if ($urandom_range(0, 7) == 0) drain_results();
        end
        drain_results();
        gaps_on = 1'b1;
    endtask

    initial begin : result_sink
        int stall;
        stall = 0;
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                res_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else if (stall > 0) begin
                stall--;
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= 1'b1;
                if ($urandom_range(0, 99) < 15) stall = pick_gap();
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        t_filt_result want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result, status %0d slot %0d count %0d", $time,
                         res_ch.status, res_ch.slot_index, res_ch.ref_count);
                fail_count++;
            end else begin
                want = expected_q.pop_front();
                n_checked++;
                if (want.status == STAT_BAD_ARG) n_bad++;
                if (want.status == STAT_FULL)    n_full++;
                if (want.status == STAT_ABSENT)  n_absent++;
                if (want.changed)                n_slot_chg++;
                if (res_ch.status !== want.status) begin
                    $display("%0t: status expected %0d, got %0d", $time,
                             want.status, res_ch.status);
                    fail_count++;
                end
                if (res_ch.slot_changed !== want.changed) begin
                    $display("%0t: slot_changed expected %0d, got %0d", $time,
                             want.changed, res_ch.slot_changed);
                    fail_count++;
                end
                if (res_ch.slot_index !== want.index) begin
                    $display("%0t: slot_index expected %0d, got %0d", $time,
                             want.index, res_ch.slot_index);
                    fail_count++;
                end
                if (res_ch.ref_count !== want.count) begin
                    $display("%0t: ref_count expected %0d, got %0d", $time,
                             want.count, res_ch.ref_count);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no item moved for %0d cycles", $time, IDLE_LIMIT);
            $display("can_filter_slot_allocator_tb NOT OK");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        fail_count   = 0;
        items_sent   = 0;
        n_checked    = 0;
        n_bad        = 0;
        n_full       = 0;
        n_absent     = 0;
        n_slot_chg   = 0;
        idle_cycles  = 0;
        gaps_on      = 1'b1;
        hold_off_req = 1'b0;
        for (int c = 0; c < NCH; c++) begin
            chan_total[c] = '0;
            for (int i = 0; i < NIDS; i++) id_refs[c][i] = '0;
            id_pool[c][0] = '0;
            id_pool[c][1] = ID_W'(NIDS - 1);
            for (int i = 2; i < POOL; i++) id_pool[c][i] = ID_W'($urandom_range(0, NIDS - 1));
        end
        for (int s = 0; s < NCH * NSLOT; s++) begin
            slot_used[s] = 1'b0;
            slot_tag[s]  = '0;
        end

        i_rst_n           <= 1'b0;
        req_ch.valid      <= 1'b0;
        req_ch.operation  <= OP_ADD;
        req_ch.message_id <= '0;
        req_ch.channel    <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_bad_args();
        test_add_delete();
        test_channel_full();
        test_backpressure();
        test_random_traffic(1600);

        drain_results();
        repeat (END_WAIT) @(posedge i_clk);

        $display("Sent %0d requests, checked %0d results: %0d slot fills/clears,",
                 items_sent, n_checked, n_slot_chg);
        $display("%0d bad-argument, %0d channel-full and %0d absent-id refusals.",
                 n_bad, n_full, n_absent);
        if (fail_count == 0) begin
            $display("can_filter_slot_allocator_tb OK");
        end else begin
            $display("can_filter_slot_allocator_tb NOT OK");
        end
        $finish;
    end

endmodule
